>>> src/tbms_pkg.sv
// shared types and constants for the timed burst memory slave
`default_nettype none
package tbms_pkg;

    localparam int QUEUE_SLOTS = 8;
    localparam int QPTR_W      = $clog2(QUEUE_SLOTS);
    localparam int ADDR_W      = 16;
    localparam int WRITE_BYTES = 16;
    localparam int READ_BYTES  = 4;
    localparam int BANK_W      = $clog2(WRITE_BYTES);
    localparam int ROW_W       = ADDR_W - BANK_W;
    localparam int RSHIFT      = $clog2(READ_BYTES);
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int PADDR_W     = 4;

    localparam logic [7:0]  READY_DELAY_RST   = 8'd3;
    localparam logic [15:0] READ_LATENCY_RST  = 16'd103;
    localparam logic [7:0]  BEAT_GAP_RST      = 8'd2;
    localparam logic [15:0] WRITE_LATENCY_RST = 16'd9;

    typedef enum logic [1:0] {
        REG_READY_DELAY   = 2'd0,
        REG_READ_LATENCY  = 2'd1,
        REG_BEAT_GAP      = 2'd2,
        REG_WRITE_LATENCY = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  ready_delay;
        logic [15:0] read_latency;
        logic [7:0]  beat_gap;
        logic [15:0] write_latency;
    } cfg_t;

    typedef struct packed {
        logic        rd_req_valid;
        logic [15:0] rd_req_addr;
        logic [7:0]  rd_req_beats;
        logic [3:0]  rd_req_id;
        logic        wr_req_valid;
        logic [15:0] wr_req_addr;
        logic [3:0]  wr_req_id;
        logic [63:0] wr_data_low;
        logic [63:0] wr_data_high;
    } req_t;

    typedef struct packed {
        logic        rd_ready;
        logic        rd_data_valid;
        logic [3:0]  rd_data_id;
        logic [31:0] rd_data;
        logic        rd_data_last;
        logic        wr_ready;
        logic        wr_resp_valid;
        logic [3:0]  wr_resp_id;
    } resp_t;

    typedef struct packed {
        logic                     rd_ready;
        logic                     rd_beat;
        logic [3:0]               rd_id;
        logic                     rd_last;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     wr_ready;
        logic                     wr_commit;
        logic [3:0]               wr_id;
        logic [ADDR_W-1:0]        wr_addr;
        logic [8*WRITE_BYTES-1:0] wr_data;
    } cmd_t;

endpackage
`default_nettype wire

>>> src/timed_burst_memory_slave.sv
// top level: config registers, front control, command queue, memory back end
//
// channel   | handshake              | beat
// ----------+------------------------+-----------------------------
// request   | push / full            | req (one tick of request pins)
// result    | empty / pop            | resp (one tick of output pins)
// config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// one request beat is taken per cycle while full is low; each gives one result beat
// a result passes the command queue, the back-end read stage and the result queue before it is visible
// after reset a pass clears all 4096 memory rows, full stays high meanwhile
// full rises when the 4-entry command queue fills, which happens only when
// results are not popped
`default_nettype none
module timed_burst_memory_slave (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire tbms_pkg::req_t               req,
    output logic                              empty,
    input  wire logic                         pop,
    output tbms_pkg::resp_t                   resp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbms_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tbms_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     step, cmd_full, cmd_empty, cmd_pop, clearing;
    cmd_t     cmd_in, cmd_out;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign full   = cmd_full || clearing;
    assign step   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_delay   <= READY_DELAY_RST;
            cfg_reg.read_latency  <= READ_LATENCY_RST;
            cfg_reg.beat_gap      <= BEAT_GAP_RST;
            cfg_reg.write_latency <= WRITE_LATENCY_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (widx)
                REG_READY_DELAY:   cfg_reg.ready_delay   <= pwdata[7:0];
                REG_READ_LATENCY:  cfg_reg.read_latency  <= pwdata[15:0];
                REG_BEAT_GAP:      cfg_reg.beat_gap      <= pwdata[7:0];
                REG_WRITE_LATENCY: cfg_reg.write_latency <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_READY_DELAY:   prdata = 32'(cfg_reg.ready_delay);
            REG_READ_LATENCY:  prdata = 32'(cfg_reg.read_latency);
            REG_BEAT_GAP:      prdata = 32'(cfg_reg.beat_gap);
            REG_WRITE_LATENCY: prdata = 32'(cfg_reg.write_latency);
            default:           prdata = 32'd0;
        endcase
    end

    tbms_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req),
        .cfg   (cfg_reg),
        .cmd   (cmd_in)
    );

    tbms_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty),
        .full  (cmd_full),
        .count (cmd_count)
    );

    tbms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .resp      (resp),
        .empty     (empty),
        .pop       (pop)
    );

    logic [$clog2(CMD_DEPTH+1)-1:0] unused_cmd_count;
    assign unused_cmd_count = cmd_count;

endmodule
`default_nettype wire

>>> src/tbms_queue.sv
// small register fifo
`default_nettype none
module tbms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic [WIDTH-1:0]                rdata,
    output logic                            empty,
    output logic                            full,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign count   = cnt_reg;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

endmodule
`default_nettype wire

>>> src/tbms_front.sv
// tick-accurate request queues and due-time control, one tick per beat
`default_nettype none
module tbms_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire tbms_pkg::req_t req,
    input  wire tbms_pkg::cfg_t cfg,
    output tbms_pkg::cmd_t      cmd
);
    import tbms_pkg::*;

    logic [31:0]       tick_reg;
    logic              rd_busy_reg, wr_busy_reg;
    logic [31:0]       rd_rdue_reg, wr_rdue_reg;

    logic [ADDR_W-1:0] rq_addr_reg  [QUEUE_SLOTS];
    logic [7:0]        rq_beats_reg [QUEUE_SLOTS];
    logic [7:0]        rq_done_reg  [QUEUE_SLOTS];
    logic [31:0]       rq_due_reg   [QUEUE_SLOTS];
    logic [3:0]        rq_id_reg    [QUEUE_SLOTS];
    logic [QPTR_W-1:0] rhead_reg, rtail_reg;

    logic [ADDR_W-1:0]        wq_addr_reg [QUEUE_SLOTS];
    logic [31:0]              wq_due_reg  [QUEUE_SLOTS];
    logic [3:0]               wq_id_reg   [QUEUE_SLOTS];
    logic [8*WRITE_BYTES-1:0] wq_data_reg [QUEUE_SLOTS];
    logic [QPTR_W-1:0]        whead_reg, wtail_reg;

    logic        rd_acc, rd_rdy, rq_empty, rd_beat, rd_last;
    logic [31:0] rd_start, h_due;
    logic [7:0]  in_beats, h_beats, h_done, done_next;
    logic [ADDR_W-1:0] h_addr;
    logic [3:0]  h_id;

    logic        wr_acc, wr_rdy, wq_empty, wr_resp;
    logic [31:0] wr_start, w_due;
    logic [ADDR_W-1:0] w_addr;
    logic [3:0]  w_id;
    logic [8*WRITE_BYTES-1:0] in_wdata, w_data;

    always_comb
    begin
        rd_acc    = !rd_busy_reg && req.rd_req_valid && (rtail_reg + 1'b1 != rhead_reg);
        rd_rdy    = !rd_acc && rd_busy_reg && (rd_rdue_reg == tick_reg);
        rq_empty  = (rhead_reg == rtail_reg);
        rd_start  = tick_reg + 32'(cfg.read_latency);
        in_beats  = (req.rd_req_beats == 8'd0) ? 8'd1 : req.rd_req_beats;
        // an empty queue takes this tick's request as its head
        h_due     = rq_empty ? rd_start          : rq_due_reg[rhead_reg];
        h_done    = rq_empty ? 8'd0              : rq_done_reg[rhead_reg];
        h_beats   = rq_empty ? in_beats          : rq_beats_reg[rhead_reg];
        h_addr    = rq_empty ? req.rd_req_addr   : rq_addr_reg[rhead_reg];
        h_id      = rq_empty ? req.rd_req_id     : rq_id_reg[rhead_reg];
        rd_beat   = (!rq_empty || rd_acc) && (h_due == tick_reg);
        done_next = h_done + 8'd1;
        rd_last   = rd_beat && (done_next >= h_beats);

        wr_acc    = !wr_busy_reg && req.wr_req_valid && (wtail_reg + 1'b1 != whead_reg);
        wr_rdy    = !wr_acc && wr_busy_reg && (wr_rdue_reg == tick_reg);
        wq_empty  = (whead_reg == wtail_reg);
        wr_start  = tick_reg + 32'(cfg.write_latency);
        in_wdata  = {req.wr_data_high, req.wr_data_low};
        w_due     = wq_empty ? wr_start        : wq_due_reg[whead_reg];
        w_addr    = wq_empty ? req.wr_req_addr : wq_addr_reg[whead_reg];
        w_id      = wq_empty ? req.wr_req_id   : wq_id_reg[whead_reg];
        w_data    = wq_empty ? in_wdata        : wq_data_reg[whead_reg];
        wr_resp   = (!wq_empty || wr_acc) && (w_due == tick_reg);

        cmd.rd_ready  = rd_rdy;
        cmd.rd_beat   = rd_beat;
        cmd.rd_id     = h_id;
        cmd.rd_last   = rd_last;
        cmd.rd_addr   = h_addr + {h_done, RSHIFT'(0)};
        cmd.wr_ready  = wr_rdy;
        cmd.wr_commit = wr_resp;
        cmd.wr_id     = w_id;
        cmd.wr_addr   = w_addr;
        cmd.wr_data   = w_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            rd_busy_reg <= 1'b0;
            wr_busy_reg <= 1'b0;
            rd_rdue_reg <= '0;
            wr_rdue_reg <= '0;
            rhead_reg   <= '0;
            rtail_reg   <= '0;
            whead_reg   <= '0;
            wtail_reg   <= '0;
        end
        else if (step)
        begin
            tick_reg <= tick_reg + 32'd1;
            if (rd_acc)
            begin
                rd_busy_reg <= 1'b1;
                rd_rdue_reg <= tick_reg + 32'(cfg.ready_delay);
                rtail_reg   <= rtail_reg + 1'b1;
            end
            else if (rd_rdy)
                rd_busy_reg <= 1'b0;
            if (rd_last)
                rhead_reg <= rhead_reg + 1'b1;
            if (wr_acc)
            begin
                wr_busy_reg <= 1'b1;
                wr_rdue_reg <= tick_reg + 32'(cfg.ready_delay);
                wtail_reg   <= wtail_reg + 1'b1;
            end
            else if (wr_rdy)
                wr_busy_reg <= 1'b0;
            if (wr_resp)
                whead_reg <= whead_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (rd_acc)
            begin
                rq_addr_reg[rtail_reg]  <= req.rd_req_addr;
                rq_beats_reg[rtail_reg] <= in_beats;
                rq_done_reg[rtail_reg]  <= 8'd0;
                rq_due_reg[rtail_reg]   <= rd_start;
                rq_id_reg[rtail_reg]    <= req.rd_req_id;
            end
            // head progress overrides a same-tick fill of the same slot
            if (rd_beat && !rd_last)
            begin
                rq_done_reg[rhead_reg] <= done_next;
                rq_due_reg[rhead_reg]  <= h_due + 32'(cfg.beat_gap);
            end
            if (wr_acc)
            begin
                wq_addr_reg[wtail_reg] <= req.wr_req_addr;
                wq_due_reg[wtail_reg]  <= wr_start;
                wq_id_reg[wtail_reg]   <= req.wr_req_id;
                wq_data_reg[wtail_reg] <= in_wdata;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/tbms_back.sv
// banked byte memory, clearing pass and result queue
`default_nettype none
module tbms_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tbms_pkg::cmd_t cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output logic                clearing,
    output tbms_pkg::resp_t     resp,
    output logic                empty,
    input  wire logic           pop
);
    import tbms_pkg::*;

    localparam int NBANK = WRITE_BYTES;
    localparam int OCW   = $clog2(OUT_DEPTH + 1);

    logic              clr_busy_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    logic              s_valid_reg;
    cmd_t              s_cmd_reg;
    logic [7:0]        bank_q [NBANK];
    logic [OCW-1:0]    ocount;
    logic              ofull;
    logic              issue;
    resp_t             res;
    logic [31:0]       word;

    assign clearing = clr_busy_reg;
    assign issue    = !cmd_empty && !clr_busy_reg
                      && ((ocount + OCW'(s_valid_reg)) < OCW'(OUT_DEPTH));
    assign cmd_pop  = issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
            s_valid_reg  <= 1'b0;
        end
        else
        begin
            s_valid_reg <= issue;
            if (clr_busy_reg)
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
                if (clr_row_reg == '1)
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            s_cmd_reg <= cmd;
    end

    // byte at address a lives in bank a mod 16, row a / 16
    for (genvar b = 0; b < NBANK; b++)
    begin : g_bank
        logic [7:0]       mem [2**ROW_W];
        logic [ROW_W-1:0] rrow, wrow;
        logic [BANK_W-1:0] wofs;
        logic             we;
        logic [7:0]       wd;

        always_comb
        begin
            rrow = cmd.rd_addr[ADDR_W-1:BANK_W]
                   + ROW_W'(BANK_W'(b) < cmd.rd_addr[BANK_W-1:0]);
            wofs = BANK_W'(b) - cmd.wr_addr[BANK_W-1:0];
            we   = clr_busy_reg || (issue && cmd.wr_commit);
            if (clr_busy_reg)
            begin
                wrow = clr_row_reg;
                wd   = 8'd0;
            end
            else
            begin
                wrow = cmd.wr_addr[ADDR_W-1:BANK_W]
                       + ROW_W'(BANK_W'(b) < cmd.wr_addr[BANK_W-1:0]);
                wd   = cmd.wr_data[8*wofs +: 8];
            end
        end

        // read returns the old byte when a commit hits the same row
        always_ff @(posedge clk)
        begin
            if (issue)
                bank_q[b] <= mem[rrow];
            if (we)
                mem[wrow] <= wd;
        end
    end

    always_comb
    begin
        for (int i = 0; i < READ_BYTES; i++)
            word[8*i +: 8] = bank_q[s_cmd_reg.rd_addr[BANK_W-1:0] + BANK_W'(i)];
        res.rd_ready      = s_cmd_reg.rd_ready;
        res.rd_data_valid = s_cmd_reg.rd_beat;
        res.rd_data_id    = s_cmd_reg.rd_beat ? s_cmd_reg.rd_id : 4'd0;
        res.rd_data       = s_cmd_reg.rd_beat ? word : 32'd0;
        res.rd_data_last  = s_cmd_reg.rd_last;
        res.wr_ready      = s_cmd_reg.wr_ready;
        res.wr_resp_valid = s_cmd_reg.wr_commit;
        res.wr_resp_id    = s_cmd_reg.wr_commit ? s_cmd_reg.wr_id : 4'd0;
    end

    tbms_queue #(
        .WIDTH ($bits(resp_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s_valid_reg),
        .wdata (res),
        .pop   (pop),
        .rdata (resp),
        .empty (empty),
        .full  (ofull),
        .count (ocount)
    );

    logic unused_ofull;
    assign unused_ofull = ofull;

endmodule
`default_nettype wire

>>> src/tbms_checker.sv
// port-level checks bound to the top level
`default_nettype none
module tbms_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            empty,
    input  wire logic            pop,
    input  wire tbms_pkg::resp_t resp,
    input  wire logic            pready
);
    // idle read lanes are zero
    a_rd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !resp.rd_data_valid) |->
        (resp.rd_data == 32'd0 && resp.rd_data_id == 4'd0 && !resp.rd_data_last))
        else $error("read lanes not zero without a beat");

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && resp.rd_data_last) |-> resp.rd_data_valid)
        else $error("last without a read beat");

    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !resp.wr_resp_valid && pready) |-> resp.wr_resp_id == 4'd0)
        else $error("write id without a response");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(resp)))
        else $error("waiting result changed");

endmodule

bind timed_burst_memory_slave tbms_checker u_tbms_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .resp   (resp),
    .pready (pready)
);
`default_nettype wire
